// ===== hw/rtl/tsm_pkg.sv =====
// ---------------------------------------------------------------------------
// tsm_pkg
// Shared types, codes and constants of the tone synthesizer / mixer.
// ---------------------------------------------------------------------------
package tsm_pkg;

    localparam int SAMPLE_DEPTH_DEF = 65536;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [16:0] FULL_LEVEL  = 17'h10000;

    typedef enum logic [1:0] {
        ACT_TONE  = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    localparam logic [1:0] ENV_LINEAR = 2'd1;
    localparam logic [1:0] ENV_EXP    = 2'd2;

    localparam logic [1:0] CFG_SOUND_LEN = 2'd0;
    localparam logic [1:0] CFG_ENV_MODE  = 2'd1;
    localparam logic [1:0] CFG_LIN_STEP  = 2'd2;
    localparam logic [1:0] CFG_DECAY     = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch request fields
        logic tinit;    // tone start: position, start phase, full level
        logic look;     // sine rom and store read for current position
        logic mul1;     // amplitude * level
        logic mul2;     // * |sine|
        logic twrite;   // accumulate tone sample, advance tone state
        logic srd;      // store read at first_index
        logic awrite;   // single add write-back
        logic clr;      // zero one store entry
        logic respond;  // register result
        logic err;      // result status
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action act;
        logic    tone_bad;
        logic    idx_bad;
        logic    tone_empty;
        logic    tone_last;
        logic    clr_last;
    } t_sts;

    // Q30 sine on [0, pi/2] by truncated Taylor series, elaboration only
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [65:0] acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed({2'b00, x});
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                acc = acc - $signed({2'b00, term});
            end else begin
                acc = acc + $signed({2'b00, term});
            end
        end
        return (acc < 0) ? 64'd0 : acc[63:0];
    endfunction

endpackage

// ===== hw/rtl/tsm_ctrl.sv =====
// ---------------------------------------------------------------------------
// tsm_ctrl
// Request sequencer: decode, per-sample tone loop, single access, clear sweep.
// ---------------------------------------------------------------------------
module tsm_ctrl
    import tsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_CLEAR   = 12'b0000_0000_0010,
        ST_DECODE  = 12'b0000_0000_0100,
        ST_T_INIT  = 12'b0000_0000_1000,
        ST_T_LOOK  = 12'b0000_0001_0000,
        ST_T_MUL1  = 12'b0000_0010_0000,
        ST_T_MUL2  = 12'b0000_0100_0000,
        ST_T_WRITE = 12'b0000_1000_0000,
        ST_S_READ  = 12'b0001_0000_0000,
        ST_A_WRITE = 12'b0010_0000_0000,
        ST_DONE    = 12'b0100_0000_0000,
        ST_SPARE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_err, n_err;
    logic   r_boot, n_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;   // store is zeroed by a sweep after reset
            r_err   <= 1'b0;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        n_boot  = r_boot;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_sts.act)
                    ACT_TONE: begin
                        n_err   = i_sts.tone_bad;
                        n_state = i_sts.tone_bad ? ST_DONE : ST_T_INIT;
                    end
                    ACT_ADD, ACT_READ: begin
                        n_err   = i_sts.idx_bad;
                        n_state = i_sts.idx_bad ? ST_DONE : ST_S_READ;
                    end
                    ACT_CLEAR: begin
                        n_err   = 1'b0;
                        n_state = ST_CLEAR;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? ST_IDLE : ST_DONE;
                end
            end
            ST_T_INIT: begin
                o_cmd.tinit = 1'b1;
                n_state     = i_sts.tone_empty ? ST_DONE : ST_T_LOOK;
            end
            ST_T_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = ST_T_MUL1;
            end
            ST_T_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_T_MUL2;
            end
            ST_T_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_T_WRITE;
            end
            ST_T_WRITE: begin
                o_cmd.twrite = 1'b1;
                n_state      = i_sts.tone_last ? ST_DONE : ST_T_LOOK;
            end
            ST_S_READ: begin
                o_cmd.srd = 1'b1;
                n_state   = (i_sts.act == ACT_ADD) ? ST_A_WRITE : ST_DONE;
            end
            ST_A_WRITE: begin
                o_cmd.awrite = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.respond = 1'b1;
                n_state       = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.err = r_err;
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== hw/rtl/tsm_dp.sv =====
// ---------------------------------------------------------------------------
// tsm_dp
// Datapath: config registers, sample store, sine rom, tone arithmetic, result.
// ---------------------------------------------------------------------------
module tsm_dp
    import tsm_pkg::*;
#(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_first_index,
    input  logic [16:0]        i_end_index,
    input  logic [31:0]        i_phase_step,
    input  logic [14:0]        i_amplitude,
    input  logic signed [15:0] i_sample_value,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_done,
    output logic               o_status,
    output logic signed [15:0] o_read_value
);

    localparam int AW   = $clog2(SAMPLE_DEPTH);
    localparam int LW   = ($clog2(SAMPLE_DEPTH + 1) > 17) ? $clog2(SAMPLE_DEPTH + 1) : 17;
    localparam int SW   = $clog2(SINE_ENTRIES);
    localparam int EW   = $clog2(SINE_ENTRIES + 1);

    // configuration
    logic [16:0] r_sound_len;
    logic [1:0]  r_env_mode;
    logic [16:0] r_lin_step;
    logic [15:0] r_decay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_len <= 17'h10000;
            r_env_mode  <= 2'd0;
            r_lin_step  <= 17'd0;
            r_decay     <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOUND_LEN: r_sound_len <= i_cfg_data;
                CFG_ENV_MODE:  r_env_mode  <= i_cfg_data[1:0];
                CFG_LIN_STEP:  r_lin_step  <= i_cfg_data;
                CFG_DECAY:     r_decay     <= i_cfg_data[15:0];
                default:       r_decay     <= r_decay;
            endcase
        end
    end

    // latched request
    t_action            r_act;
    logic [15:0]        r_first;
    logic [16:0]        r_end;
    logic [31:0]        r_step;
    logic [14:0]        r_amp;
    logic signed [15:0] r_sval;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= t_action'(i_action);
            r_first <= i_first_index;
            r_end   <= i_end_index;
            r_step  <= i_phase_step;
            r_amp   <= i_amplitude;
            r_sval  <= i_sample_value;
        end
    end

    logic [LW-1:0] w_lim;
    assign w_lim = (LW'(r_sound_len) < LW'(SAMPLE_DEPTH)) ? LW'(r_sound_len) : LW'(SAMPLE_DEPTH);

    // sine rom, built at elaboration
    logic signed [15:0] w_rom [SINE_ENTRIES];
    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] U    = 64'(4 * k);
        localparam logic [63:0] Q    = U / SINE_ENTRIES;
        localparam logic [63:0] R    = U % SINE_ENTRIES;
        localparam logic [63:0] RR   = Q[0] ? 64'(SINE_ENTRIES) - R : R;
        localparam logic [63:0] X    = (HALF_PI_Q30 * RR) / SINE_ENTRIES;
        localparam logic [63:0] MAG0 = (quarter_sine_q30(X) * 64'd32768 + 64'h2000_0000) >> 30;
        localparam logic [15:0] MAG  = (MAG0 > 64'd32767) ? 16'd32767 : MAG0[15:0];
        assign w_rom[k] = (Q >= 64'd2) ? -$signed(MAG) : $signed(MAG);
    end

    // tone state
    logic [16:0] r_pos;
    logic [31:0] r_phase;
    logic [16:0] r_env;
    logic [16:0] n_env;

    logic signed [15:0] r_sine;
    logic signed [15:0] r_rd;
    logic               r_neg;
    logic [15:0]        r_mag;
    logic [31:0]        r_p1;
    logic [46:0]        r_p2;

    logic [31+EW:0] w_idx_full;
    logic [SW-1:0]  w_idx;
    assign w_idx_full = {{EW{1'b0}}, r_phase} * (32 + EW)'(SINE_ENTRIES);
    assign w_idx      = SW'(w_idx_full >> 32);

    logic [32:0] w_decay_prod;
    assign w_decay_prod = r_env * r_decay;

    always_comb begin
        if (r_env_mode == ENV_LINEAR) begin
            n_env = (r_env > r_lin_step) ? r_env - r_lin_step : 17'd0;
        end else if (r_env_mode == ENV_EXP) begin
            n_env = w_decay_prod[32:16];
        end else begin
            n_env = r_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 17'd0;
            r_phase <= 32'd0;
            r_env   <= FULL_LEVEL;
        end else if (i_cmd.tinit) begin
            r_pos   <= 17'(r_first);
            r_phase <= 32'(r_first * r_step);
            r_env   <= FULL_LEVEL;
        end else if (i_cmd.twrite) begin
            r_pos   <= r_pos + 17'd1;
            r_phase <= r_phase + r_step;
            r_env   <= n_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_sine <= w_rom[w_idx];
        end
        if (i_cmd.mul1) begin
            r_neg <= r_sine[15];
            r_mag <= r_sine[15] ? 16'(-r_sine) : 16'(r_sine);
            r_p1  <= r_amp * r_env;
        end
        if (i_cmd.mul2) begin
            r_p2 <= r_p1 * r_mag[14:0];
        end
    end

    // saturating accumulate
    logic signed [16:0] w_tone_v;
    logic signed [17:0] w_sum;
    logic signed [15:0] w_sat;
    assign w_tone_v = r_neg ? -$signed({1'b0, r_p2[46:31]}) : $signed({1'b0, r_p2[46:31]});
    assign w_sum    = 18'(r_rd) + (i_cmd.twrite ? 18'(w_tone_v) : 18'(r_sval));
    assign w_sat    = (w_sum > 18'sd32767)  ? 16'sh7FFF :
                      (w_sum < -18'sd32768) ? 16'sh8000 : w_sum[15:0];

    // sample store
    logic [15:0]   r_mem [SAMPLE_DEPTH];
    logic [AW-1:0] r_clr_addr;
    logic          w_clr_last;
    assign w_clr_last = (r_clr_addr == AW'(SAMPLE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= w_clr_last ? '0 : r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.twrite) begin
            r_mem[AW'(r_pos)] <= w_sat;
        end else if (i_cmd.awrite) begin
            r_mem[AW'(r_first)] <= w_sat;
        end
        if (i_cmd.look) begin
            r_rd <= r_mem[AW'(r_pos)];
        end else if (i_cmd.srd) begin
            r_rd <= r_mem[AW'(r_first)];
        end
    end

    assign o_sts.act        = r_act;
    assign o_sts.tone_bad   = (17'(r_first) > r_end) || (LW'(r_end) > w_lim);
    assign o_sts.idx_bad    = (LW'(r_first) >= w_lim);
    assign o_sts.tone_empty = (17'(r_first) == r_end);
    assign o_sts.tone_last  = ((r_pos + 17'd1) == r_end);
    assign o_sts.clr_last   = w_clr_last;

    // result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            o_status     <= i_cmd.err;
            o_read_value <= (r_act == ACT_READ && !i_cmd.err) ? r_rd : 16'sd0;
        end
    end

endmodule

// ===== hw/rtl/tone_synth_mixer_core.sv =====
// ---------------------------------------------------------------------------
// tone_synth_mixer_core
// Sine tone synthesizer and mixer over a 16-bit PCM sample store.
// ---------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is low,
// and its result appears on o_status / o_read_value for the single cycle that
// o_done is high, which is the first cycle with busy low again; the receiver
// cannot stall it, so it must sample on o_done. A read passes decode and one store read;
// a single add adds a store write-back; a rejected request goes from decode to the result;
// a tone makes one store read-modify-write and two multiplies per covered sample; clear sweeps the store.
// After reset the store is zeroed by a sweep over all SAMPLE_DEPTH entries with busy
// high; configuration writes are taken at any time (write only while idle).
module tone_synth_mixer_core
    import tsm_pkg::*;
#(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_first_index,
    input  logic [16:0]        i_end_index,
    input  logic [31:0]        i_phase_step,
    input  logic [14:0]        i_amplitude,
    input  logic signed [15:0] i_sample_value,
    output logic               o_done,
    output logic               o_status,
    output logic signed [15:0] o_read_value
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    tsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tsm_dp #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_first_index  (i_first_index),
        .i_end_index    (i_end_index),
        .i_phase_step   (i_phase_step),
        .i_amplitude    (i_amplitude),
        .i_sample_value (i_sample_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_read_value   (o_read_value)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised after accept");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("result without a request in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status |-> o_read_value == 16'sd0) else $error("nonzero data on error");

endmodule
